// ===== hdl/mpm_pkg.sv =====
// Shared types and constants of the eight-channel PCM mixer.
package mpm_pkg;

  localparam int NUM_CHANNELS = 8;

  localparam logic [1:0] MODE_MIX   = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_VOL   = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  localparam logic [11:0] FRAME_LEN_RST = 12'd315;
  localparam int          SUM_W         = 18;
  localparam int          PROD_W        = 29;

  // scale per active count: 65536*128 / (16129 * count)
  localparam logic [9:0] SCALE_TAB [0:8] = '{
    10'd0,
    10'(8388608 / (16129 * 1)),
    10'(8388608 / (16129 * 2)),
    10'(8388608 / (16129 * 3)),
    10'(8388608 / (16129 * 4)),
    10'(8388608 / (16129 * 5)),
    10'(8388608 / (16129 * 6)),
    10'(8388608 / (16129 * 7)),
    10'(8388608 / (16129 * 8))
  };

  typedef struct packed {
    logic        valid;
    logic [1:0]  mode;
    logic [2:0]  channel;
    logic [15:0] length;
    logic [6:0]  volume;
  } cmd_t;

  typedef struct packed {
    logic                    tok;
    logic signed [SUM_W-1:0] sum;
  } link_t;

endpackage

// ===== hdl/mpm_cell.sv =====
// One channel cell: channel state, adds its term to the passing partial sum.
module mpm_cell
  import mpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] cell_idx,
  input  cmd_t       cmd,
  input  logic [7:0] sample,
  input  link_t      link_in,
  output link_t      link_out,
  output logic       active
);

  logic              active_r, active_nxt;
  logic [15:0]       pos_r, pos_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [6:0]        vol_r, vol_nxt;
  link_t             link_r, link_nxt;
  logic signed [7:0] centered;
  logic signed [15:0] term;
  logic              hit;

  assign centered = $signed({~sample[7], sample[6:0]});
  assign term     = centered * $signed({1'b0, vol_r});
  assign hit      = cmd.valid && (cmd.channel == cell_idx);

  always_comb begin
    active_nxt   = active_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    vol_nxt      = vol_r;
    link_nxt.tok = link_in.tok;
    link_nxt.sum = link_in.sum;
    if (link_in.tok && active_r) begin
      if (pos_r >= len_r) begin
        active_nxt = 1'b0;
      end else begin
        link_nxt.sum = link_in.sum + SUM_W'(term);
        pos_nxt      = pos_r + 16'd1;
      end
    end
    if (hit) begin
      unique case (cmd.mode)
        MODE_START: begin
          if (cmd.length != 16'd0) begin
            active_nxt = 1'b1;
            pos_nxt    = 16'd0;
            len_nxt    = cmd.length;
            vol_nxt    = cmd.volume;
          end
        end
        MODE_VOL:  vol_nxt    = cmd.volume;
        MODE_STOP: active_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      pos_r      <= '0;
      len_r      <= '0;
      vol_r      <= '0;
      link_r.tok <= 1'b0;
    end else begin
      active_r   <= active_nxt;
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      vol_r      <= vol_nxt;
      link_r.tok <= link_nxt.tok;
    end
    link_r.sum <= link_nxt.sum;
  end

  assign link_out = link_r;
  assign active   = active_r;

endmodule

// ===== hdl/multichannel_pcm_mixer_top.sv =====
// Top level of the eight-channel PCM mixer: control, scale, output stage.
//
//  channel | ports                        | payload
//  --------+------------------------------+------------------------------------
//  input   | in_tvalid/in_tready          | tuser: mode; tdata: channel, length,
//          |                              |   volume, sample_0..sample_7
//  result  | out_tvalid/out_tready        | tdata: mixed_sample, playing_mask,
//          |                              |   accepted
//  config  | cfg_valid/cfg_ready          | cfg_data: frame_length
//
// A mix transaction walks the partial sum along the row of channel cells one
// cell per cycle, then scales it into the product register and clips it into
// the output register. One transaction is in work at a time; a stalled result
// waits in the output register while the next one is taken.
// Reset (rst_n low, synchronous) clears all channels and the frame position.
module multichannel_pcm_mixer_top
  import mpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // [2:0] channel, [18:3] length, [25:19] volume, [33:26] sample_0 ...
  // [89:82] sample_7, [95:90] zero
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] mixed_sample, [23:16] playing_mask, [24] accepted, [31:25] zero
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHAIN = 2'd1;
  localparam logic [1:0] S_MUL   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [11:0] frame_len_r;
  logic [11:0] frame_pos_r, frame_pos_nxt, frame_pos_inc;
  logic [9:0]  scale_r;
  cmd_t        cmd_r;
  logic        go_r;
  logic        acc_r;
  logic [7:0]  samp_r [NUM_CHANNELS];
  logic signed [PROD_W-1:0] prod_r;
  logic        out_valid_r;
  logic [15:0] out_sample_r;
  logic [7:0]  out_mask_r;
  logic        out_acc_r;

  link_t       link [NUM_CHANNELS+1];
  logic [NUM_CHANNELS-1:0] active;
  logic [NUM_CHANNELS-1:0] toks;
  logic [3:0]  active_cnt;
  logic        in_fire;
  logic        out_free;
  logic signed [PROD_W-9:0] shifted;
  logic [15:0] clipped;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  assign link[0].tok = go_r;
  assign link[0].sum = '0;

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
    mpm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (3'(i)),
      .cmd      (cmd_r),
      .sample   (samp_r[i]),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .active   (active[i])
    );
    assign toks[i] = link[i+1].tok;
  end

  always_comb begin
    active_cnt = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      active_cnt = active_cnt + {3'd0, active[i]};
    end
  end

  assign frame_pos_inc = frame_pos_r + 12'd1;
  assign frame_pos_nxt = (frame_pos_inc >= frame_len_r) ? 12'd0 : frame_pos_inc;

  assign shifted = prod_r[PROD_W-1:8];
  always_comb begin
    if (shifted > 21'sd32767) begin
      clipped = 16'h7FFF;
    end else if (shifted < -21'sd32768) begin
      clipped = 16'h8000;
    end else begin
      clipped = shifted[15:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_tuser == MODE_MIX) ? S_CHAIN : S_MUL;
        end
      end
      S_CHAIN: begin
        if (link[NUM_CHANNELS].tok) begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frame_len_r <= FRAME_LEN_RST;
      frame_pos_r <= '0;
      scale_r     <= '0;
      cmd_r.valid <= 1'b0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r.valid <= in_fire && (in_tuser != MODE_MIX);
      go_r        <= in_fire && (in_tuser == MODE_MIX);
      if (cfg_valid) begin
        frame_len_r <= cfg_data;
      end
      if (in_fire && (in_tuser == MODE_MIX)) begin
        if (frame_pos_r == 12'd0) begin
          scale_r <= SCALE_TAB[active_cnt];
        end
        frame_pos_r <= frame_pos_nxt;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      cmd_r.mode    <= in_tuser;
      cmd_r.channel <= in_tdata[2:0];
      cmd_r.length  <= in_tdata[18:3];
      cmd_r.volume  <= in_tdata[25:19];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_r         <= !((in_tuser == MODE_START) && (in_tdata[18:3] == 16'd0));
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        samp_r[i] <= in_tdata[26 + 8*i +: 8];
      end
    end
    if (state_r == S_CHAIN && link[NUM_CHANNELS].tok) begin
      prod_r <= link[NUM_CHANNELS].sum * $signed({1'b0, scale_r});
    end else if (state_r == S_MUL) begin
      prod_r <= '0;
    end
    if (state_r == S_DONE && out_free) begin
      out_sample_r <= clipped;
      out_mask_r   <= active;
      out_acc_r    <= acc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_acc_r, out_mask_r, out_sample_r};

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(toks))
    else $error("more than one cell holds the sum token");

  a_token_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (toks != '0) |-> (state_r == S_CHAIN))
    else $error("sum token outside of a mix transaction");

  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    scale_r <= SCALE_TAB[1])
    else $error("scale above single channel value");

  a_reject_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[24]) |-> (out_tdata[15:0] == 16'd0))
    else $error("rejected start carries a nonzero sample");

endmodule

// ===== tb/sv/multichannel_pcm_mixer_top_tb.sv =====
// Self-checking testbench of the eight-channel PCM mixer top level.
module multichannel_pcm_mixer_top_tb;
  import mpm_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;

  typedef struct packed {
    logic [1:0]      mode;
    logic [2:0]      chan;
    logic [15:0]     len;
    logic [6:0]      vol;
    logic [7:0][7:0] smp;
  } mix_item_t;

  typedef struct packed {
    logic signed [15:0] pcm;
    logic [7:0]         mask;
    logic               acc;
  } mix_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int err_count = 0;
  int cycles = 0;

  mix_result_t pending_mix_results[$];

  // mixer state as seen by the predictor
  logic [11:0] frame_len_m;
  logic [7:0]  active_m;
  logic [15:0] pos_m [8];
  logic [15:0] len_m [8];
  logic [6:0]  vol_m [8];
  logic [11:0] frame_pos_m;
  logic [9:0]  scale_m;

  multichannel_pcm_mixer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever begin
      #10 clk = ~clk;
    end
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("multichannel_pcm_mixer_top test failed");
    $finish;
  end

  function automatic void reset_mix_model();
    frame_len_m = FRAME_LEN_RST;
    active_m    = '0;
    frame_pos_m = '0;
    scale_m     = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      pos_m[i] = '0;
      len_m[i] = '0;
      vol_m[i] = '0;
    end
  endfunction

  function automatic mix_result_t predict_mix_result(mix_item_t it);
    mix_result_t r;
    longint      total;
    longint      prod;
    longint      q;
    int          count;
    r.pcm = '0;
    r.acc = 1'b1;
    case (it.mode)
      MODE_MIX: begin
        if (frame_pos_m == 0) begin
          count = $countones(active_m);
          scale_m = (count != 0) ? 10'(8388608 / (16129 * count)) : 10'd0;
        end
        frame_pos_m = frame_pos_m + 12'd1;
        if (frame_pos_m >= frame_len_m) frame_pos_m = '0;
        total = 0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (active_m[i]) begin
            if (pos_m[i] >= len_m[i]) begin
              active_m[i] = 1'b0;
            end else begin
              total += (longint'(it.smp[i]) - 128) * longint'(vol_m[i]);
              pos_m[i] = pos_m[i] + 16'd1;
            end
          end
        end
        prod = total * longint'(scale_m);
        q = prod >>> 8;
        if (q > 32767) q = 32767;
        else if (q < -32768) q = -32768;
        r.pcm = q[15:0];
      end
      MODE_START: begin
        if (it.len == 0) begin
          r.acc = 1'b0;
        end else begin
          active_m[it.chan] = 1'b1;
          len_m[it.chan]    = it.len;
          pos_m[it.chan]    = '0;
          vol_m[it.chan]    = it.vol;
        end
      end
      MODE_VOL: begin
        vol_m[it.chan] = it.vol;
      end
      default: begin
        active_m[it.chan] = 1'b0;
      end
    endcase
    r.mask = active_m;
    return r;
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  function automatic mix_item_t cmd_item(logic [1:0] mode, logic [2:0] chan,
                                         logic [15:0] len, logic [6:0] vol);
    mix_item_t it;
    it.mode = mode;
    it.chan = chan;
    it.len  = len;
    it.vol  = vol;
    for (int i = 0; i < 8; i++) it.smp[i] = rand_byte();
    return it;
  endfunction

  function automatic mix_item_t mix_fill(logic [7:0] b);
    mix_item_t it;
    it = cmd_item(MODE_MIX, 3'($urandom), 16'($urandom), 7'($urandom));
    for (int i = 0; i < 8; i++) it.smp[i] = b;
    return it;
  endfunction

  function automatic mix_item_t rand_item();
    mix_item_t it;
    int        pick;
    int        lsel;
    pick = $urandom_range(99);
    lsel = $urandom_range(99);
    it = cmd_item(MODE_MIX, 3'($urandom), 16'($urandom), 7'($urandom));
    if (pick >= 90) begin
      it.mode = MODE_STOP;
    end else if (pick >= 80) begin
      it.mode = MODE_VOL;
    end else if (pick >= 65) begin
      it.mode = MODE_START;
      if (lsel < 8) it.len = '0;
      else if (lsel >= 20) it.len = 16'($urandom_range(1, 64));
    end
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    mix_result_t got;
    mix_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pcm  = out_tdata[15:0];
      got.mask = out_tdata[23:16];
      got.acc  = out_tdata[24];
      if (pending_mix_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        err_count++;
      end else begin
        want = pending_mix_results.pop_front();
        if (got.pcm !== want.pcm) begin
          $display("%0t: mixed_sample exp %0d got %0d", $time, want.pcm, got.pcm);
          err_count++;
        end
        if (got.mask !== want.mask) begin
          $display("%0t: playing_mask exp %h got %h", $time, want.mask, got.mask);
          err_count++;
        end
        if (got.acc !== want.acc) begin
          $display("%0t: accepted exp %b got %b", $time, want.acc, got.acc);
          err_count++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // called at a falling edge; returns at a falling edge with tvalid still high
  task automatic send_item(mix_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.mode;
    in_tdata  <= {6'b0, it.smp, it.vol, it.len, it.chan};
    do @(posedge clk); while (!in_tready);
    pending_mix_results.push_back(predict_mix_result(it));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_mix_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_frame_length(logic [11:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    frame_len_m = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_frame_length(12'd2);
    send_item(mix_fill(8'hff));
    send_item(cmd_item(MODE_START, 3'd0, 16'd0, 7'd127));
    send_item(cmd_item(MODE_VOL, 3'd6, 16'd0, 7'd127));
    send_item(cmd_item(MODE_STOP, 3'd7, 16'd0, 7'd0));
    send_item(cmd_item(MODE_START, 3'd0, 16'd4, 7'd127));
    send_item(mix_fill(8'hff));
    send_item(mix_fill(8'hff));
    for (int c = 1; c < 8; c++) begin
      send_item(cmd_item(MODE_START, 3'(c), 16'hffff, 7'd127));
    end
    // scale still from one channel: clips high
    send_item(mix_fill(8'hff));
    send_item(mix_fill(8'h00));
    send_item(mix_fill(8'h80));
    send_item(cmd_item(MODE_VOL, 3'd2, 16'd0, 7'd0));
    send_item(cmd_item(MODE_STOP, 3'd7, 16'd0, 7'd0));
    send_item(rand_item());
    send_item(mix_fill(8'h01));
    send_item(mix_fill(8'hfe));
  endtask

  task automatic test_random_phase(int n, int idle_pct, int stall_pct,
                                   logic [11:0] flen);
    write_frame_length(flen);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n; k++) send_item(rand_item());
  endtask

  task automatic test_backpressure(int n);
    write_frame_length(FRAME_LEN_RST);
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    for (int k = 0; k < n; k++) begin
      send_item(rand_item());
      if (k == n / 2) wait_drained();
    end
  endtask

  initial begin
    reset_mix_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_phase(450, 0, 0, 12'd4095);
    test_random_phase(450, 74, 0, 12'd1);
    test_random_phase(450, 0, 74, 12'($urandom_range(2, 64)));
    test_random_phase(450, 27, 27, 12'($urandom_range(1, 4095)));
    test_backpressure(160);
    wait_drained();
    if (err_count == 0) begin
      $display("multichannel_pcm_mixer_top test passed");
    end else begin
      $display("multichannel_pcm_mixer_top test failed");
    end
    $finish;
  end

endmodule

// ===== multichannel_pcm_mixer_top.f =====
hdl/mpm_pkg.sv
hdl/mpm_cell.sv
hdl/multichannel_pcm_mixer_top.sv
tb/sv/multichannel_pcm_mixer_top_tb.sv
